/* rtl/core/srs_pkg.sv */
package srs_pkg;

  localparam int MAX_SCENES = 16;
  localparam int IDX_W      = $clog2(MAX_SCENES);
  localparam int CNT_W      = $clog2(MAX_SCENES + 1);
  localparam int MASK_W     = 16;
  localparam int COUNT_W    = 5;
  localparam int SCENE_W    = 4;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  typedef enum logic [2:0] {
    OP_NEXT     = 3'd0,
    OP_PREV     = 3'd1,
    OP_SKIP     = 3'd2,
    OP_AUTO     = 3'd3,
    OP_SET_NET  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    REG_SCENE_COUNT  = 2'd0,
    REG_CLOCK_MASK   = 2'd1,
    REG_NETWORK_MASK = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REDUCE,
    S_SCAN,
    S_DONE
  } state_t;

  function automatic logic flag_at(input logic [MASK_W-1:0] mask,
                                   input logic [IDX_W-1:0] idx);
    logic [MASK_W-1:0] shifted;
    shifted = mask >> idx;
    return shifted[0];
  endfunction

  function automatic logic [CNT_W-1:0] live_count(input logic [COUNT_W-1:0] count);
    if (int'(count) > MAX_SCENES) begin
      return CNT_W'(MAX_SCENES);
    end
    return CNT_W'(count);
  endfunction

endpackage

/* rtl/core/scene_rotation_selector.sv */
// Scene rotation selector.
// Commands arrive on the cmd channel (opcode, target_index, network_up) and
// each produces exactly one result transaction on the res channel
// (current_scene, switched, left_scene). Both channels use valid and ready.
// The scene count and the clock and needs-network masks are written over the
// APB port; the user must do so only while the block is idle, and the block
// itself does not enforce it. pready is always high. One command occupies
// the block from acceptance until its result is loaded into the output
// register; cmd_ready is low meanwhile. Skip, set-network without a forced
// move, and no-op commands go straight to the done state. Next, previous and
// a forced move step one scene per cycle through a single index stepper, up
// to 16 steps. Auto-advance first reduces the group cursor modulo the count
// by repeated subtraction (up to 15 subtractions) and then scans, and may
// repeat both for the other group.
// When the receiver stalls, a finished result waits in the output register
// and the next command may be accepted; its result is held back until the
// previous transaction completes.
// Synchronous reset selects scene 0, network down, both cursors unset and
// the non-clock group first; the configuration registers clear to zero.
module scene_rotation_selector
  import srs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  logic [2:0]           opcode,
  input  logic [3:0]           target_index,
  input  logic                 network_up,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [SCENE_W-1:0]   current_scene,
  output logic                 switched,
  output logic [SCENE_W-1:0]   left_scene,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  state_t               state, state_next;
  logic [COUNT_W-1:0]   scene_count, scene_count_next;
  logic [MASK_W-1:0]    clock_mask, clock_mask_next;
  logic [MASK_W-1:0]    needs_network_mask, needs_network_mask_next;
  logic [IDX_W-1:0]     active_index, active_index_next;
  logic                 network_available, network_available_next;
  logic [IDX_W-1:0]     clock_cursor, clock_cursor_next;
  logic                 clock_shown, clock_shown_next;
  logic [IDX_W-1:0]     nonclock_cursor, nonclock_cursor_next;
  logic                 nonclock_shown, nonclock_shown_next;
  logic                 want_clock_next, want_clock_next_next;
  logic [IDX_W-1:0]     pos, pos_next;
  logic [CNT_W-1:0]     steps, steps_next;
  logic                 forward, forward_next;
  logic                 group_scan, group_scan_next;
  logic                 want_clk, want_clk_next;
  logic                 second, second_next;
  logic                 sw, sw_next;
  logic [IDX_W-1:0]     left, left_next;
  logic                 res_valid_next;
  logic [SCENE_W-1:0]   current_scene_next, left_scene_next;
  logic                 switched_next;

  logic [CNT_W-1:0]     n;
  logic [IDX_W-1:0]     step_pos;
  logic                 hit;
  logic                 cfg_write;
  logic [1:0]           reg_sel;
  logic                 auto_wc;
  logic                 valid_new;

  assign pready    = 1'b1;
  assign cmd_ready = (state == S_IDLE);
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = paddr[3:2];
  assign n         = live_count(scene_count);

  always_comb begin
    if (forward) begin
      step_pos = ((CNT_W'(pos) + CNT_W'(1)) >= n) ? '0 : pos + IDX_W'(1);
    end else begin
      step_pos = (pos == '0) ? IDX_W'(n - CNT_W'(1)) : pos - IDX_W'(1);
    end
    hit = (network_available || !flag_at(needs_network_mask, step_pos)) &&
          (!group_scan || (flag_at(clock_mask, step_pos) == want_clk));
  end

  always_comb begin
    unique case (reg_sel)
      REG_SCENE_COUNT:  prdata = DATA_W'(scene_count);
      REG_CLOCK_MASK:   prdata = DATA_W'(clock_mask);
      REG_NETWORK_MASK: prdata = DATA_W'(needs_network_mask);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    state_next              = state;
    scene_count_next        = scene_count;
    clock_mask_next         = clock_mask;
    needs_network_mask_next = needs_network_mask;
    active_index_next       = active_index;
    network_available_next  = network_available;
    clock_cursor_next       = clock_cursor;
    clock_shown_next        = clock_shown;
    nonclock_cursor_next    = nonclock_cursor;
    nonclock_shown_next     = nonclock_shown;
    want_clock_next_next    = want_clock_next;
    pos_next                = pos;
    steps_next              = steps;
    forward_next            = forward;
    group_scan_next         = group_scan;
    want_clk_next           = want_clk;
    second_next             = second;
    sw_next                 = sw;
    left_next               = left;
    res_valid_next          = res_valid;
    current_scene_next      = current_scene;
    switched_next           = switched;
    left_scene_next         = left_scene;
    auto_wc                 = want_clock_next;
    valid_new               = 1'b0;

    if (res_valid && res_ready) begin
      res_valid_next = 1'b0;
    end

    if (cfg_write) begin
      unique case (reg_sel)
        REG_SCENE_COUNT: begin
          scene_count_next = pwdata[COUNT_W-1:0];
          if (CNT_W'(active_index) >= live_count(pwdata[COUNT_W-1:0])) begin
            active_index_next = '0;
          end
        end
        REG_CLOCK_MASK:   clock_mask_next = pwdata[MASK_W-1:0];
        REG_NETWORK_MASK: needs_network_mask_next = pwdata[MASK_W-1:0];
        default: ;
      endcase
    end

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          sw_next    = 1'b0;
          left_next  = '0;
          second_next = 1'b0;
          steps_next = '0;
          state_next = S_DONE;
          if (opcode == OP_SET_NET) begin
            network_available_next = network_up;
            valid_new = network_up || !flag_at(needs_network_mask, active_index);
            if (n != '0 && !valid_new) begin
              pos_next        = active_index;
              forward_next    = 1'b1;
              group_scan_next = 1'b0;
              state_next      = S_SCAN;
            end
          end else if (n != '0) begin
            if (opcode == OP_NEXT || opcode == OP_PREV) begin
              pos_next        = active_index;
              forward_next    = (opcode == OP_NEXT);
              group_scan_next = 1'b0;
              state_next      = S_SCAN;
            end else if (opcode == OP_SKIP) begin
              if (CNT_W'(target_index) < n && IDX_W'(target_index) != active_index &&
                  (network_available ||
                   !flag_at(needs_network_mask, IDX_W'(target_index)))) begin
                sw_next           = 1'b1;
                left_next         = active_index;
                active_index_next = IDX_W'(target_index);
                if (flag_at(clock_mask, IDX_W'(target_index))) begin
                  clock_cursor_next    = IDX_W'(target_index);
                  clock_shown_next     = 1'b1;
                  want_clock_next_next = 1'b0;
                end else begin
                  nonclock_cursor_next = IDX_W'(target_index);
                  nonclock_shown_next  = 1'b1;
                  want_clock_next_next = 1'b1;
                end
              end
            end else if (opcode == OP_AUTO) begin
              forward_next    = 1'b1;
              group_scan_next = 1'b1;
              want_clk_next   = auto_wc;
              if (auto_wc ? clock_shown : nonclock_shown) begin
                pos_next   = auto_wc ? clock_cursor : nonclock_cursor;
                state_next = S_REDUCE;
              end else begin
                pos_next   = IDX_W'(n - CNT_W'(1));
                state_next = S_SCAN;
              end
            end
          end
        end
      end

      S_REDUCE: begin
        if (CNT_W'(pos) >= n) begin
          pos_next = pos - IDX_W'(n);
        end else begin
          state_next = S_SCAN;
        end
      end

      S_SCAN: begin
        steps_next = steps + CNT_W'(1);
        pos_next   = step_pos;
        if (hit) begin
          state_next = S_DONE;
          if (!group_scan) begin
            sw_next           = 1'b1;
            left_next         = active_index;
            active_index_next = step_pos;
            if (flag_at(clock_mask, step_pos)) begin
              clock_cursor_next    = step_pos;
              clock_shown_next     = 1'b1;
              want_clock_next_next = 1'b0;
            end else begin
              nonclock_cursor_next = step_pos;
              nonclock_shown_next  = 1'b1;
              want_clock_next_next = 1'b1;
            end
          end else begin
            if (step_pos != active_index) begin
              sw_next           = 1'b1;
              left_next         = active_index;
              active_index_next = step_pos;
            end
            if (want_clk) begin
              clock_cursor_next = step_pos;
              clock_shown_next  = 1'b1;
            end else begin
              nonclock_cursor_next = step_pos;
              nonclock_shown_next  = 1'b1;
            end
            want_clock_next_next = !want_clk;
          end
        end else if (steps + CNT_W'(1) == n) begin
          if (group_scan && !second) begin
            second_next   = 1'b1;
            want_clk_next = !want_clk;
            steps_next    = '0;
            if (!want_clk ? clock_shown : nonclock_shown) begin
              pos_next   = !want_clk ? clock_cursor : nonclock_cursor;
              state_next = S_REDUCE;
            end else begin
              pos_next   = IDX_W'(n - CNT_W'(1));
            end
          end else begin
            state_next = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!res_valid || res_ready) begin
          res_valid_next     = 1'b1;
          current_scene_next = SCENE_W'(active_index);
          switched_next      = sw;
          left_scene_next    = sw ? SCENE_W'(left) : '0;
          state_next         = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      scene_count        <= '0;
      clock_mask         <= '0;
      needs_network_mask <= '0;
      active_index       <= '0;
      network_available  <= 1'b0;
      clock_cursor       <= '0;
      clock_shown        <= 1'b0;
      nonclock_cursor    <= '0;
      nonclock_shown     <= 1'b0;
      want_clock_next    <= 1'b0;
      res_valid          <= 1'b0;
    end else begin
      state              <= state_next;
      scene_count        <= scene_count_next;
      clock_mask         <= clock_mask_next;
      needs_network_mask <= needs_network_mask_next;
      active_index       <= active_index_next;
      network_available  <= network_available_next;
      clock_cursor       <= clock_cursor_next;
      clock_shown        <= clock_shown_next;
      nonclock_cursor    <= nonclock_cursor_next;
      nonclock_shown     <= nonclock_shown_next;
      want_clock_next    <= want_clock_next_next;
      res_valid          <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos           <= pos_next;
    steps         <= steps_next;
    forward       <= forward_next;
    group_scan    <= group_scan_next;
    want_clk      <= want_clk_next;
    second        <= second_next;
    sw            <= sw_next;
    left          <= left_next;
    current_scene <= current_scene_next;
    switched      <= switched_next;
    left_scene    <= left_scene_next;
  end

endmodule
